/* sv/irpse_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the pulse symbol encoder.
package irpse_pkg;

    localparam int DUR_W        = 15;
    localparam int SYM_W        = 32;
    localparam int LIMIT_W      = 12;
    localparam int BYTE_W       = 8;
    localparam int NBITS_W      = 4;
    localparam int REG_IDX_W    = 3;
    localparam int QUEUE_DEPTH  = 4;
    localparam int BIT_IDX_MAX  = 7;

    localparam logic [NBITS_W-1:0] BITS_PER_BYTE = NBITS_W'(8);

    localparam logic [REG_IDX_W-1:0] REG_HEADER_MARK  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_HEADER_SPACE = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SYM_ZERO     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SYM_ONE      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FOOTER_MARK  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_FOOTER_SPACE = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_BIT_LIMIT    = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_MSB_LEAD     = 3'd7;

    typedef enum logic [1:0] {
        FOOT_NONE,
        FOOT_MARK,
        FOOT_SPACE
    } t_foot;

    typedef struct packed {
        logic [DUR_W-1:0] header_mark;
        logic [DUR_W-1:0] header_space;
        logic [SYM_W-1:0] sym_zero;
        logic [SYM_W-1:0] sym_one;
        logic [DUR_W-1:0] footer_mark;
        logic [DUR_W-1:0] footer_space;
        logic [LIMIT_W-1:0] bit_limit;
        logic             msb_lead;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0]  data_byte;
        logic               hdr;
        logic [NBITS_W-1:0] nbits;
        t_foot              foot;
        logic               last;
    } t_cmd;

    typedef struct packed {
        logic             second_level;
        logic [DUR_W-1:0] second_duration;
        logic             first_level;
        logic [DUR_W-1:0] first_duration;
    } t_sym;

endpackage

/* sv/ir_pulse_symbol_encoder_unit.sv */
`timescale 1ns / 1ps
// The first symbol of a byte passes through the command queue and the sequencer's output register.
// The sequencer issues one symbol per cycle while the output is not stalled; a queued byte gives
//   1 to 10 symbols (header + up to eight bits + footer), bytes with no symbols are not queued.
// A four-entry command queue lets input and output stall independently.
// Reset: synchronous active low; registers to defaults, queue empty, frame closed.
// Top level of the pulse symbol encoder.
module ir_pulse_symbol_encoder_unit #(
    parameter int COUNT_BITS = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [irpse_pkg::REG_IDX_W-1:0] i_cfg_index,
    input  logic [irpse_pkg::SYM_W-1:0]     i_cfg_data,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [7:0]                      i_s_axis_tdata,  // data_byte[7:0]
    input  logic                            i_s_axis_tlast,  // final_byte
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // first_duration[14:0], first_level[15], second_duration[30:16], second_level[31]
    output logic [31:0]                     o_m_axis_tdata,
    output logic                            o_m_axis_tlast,  // frame_done
    output logic                            o_m_axis_tuser   // item_done
);
    import irpse_pkg::*;

    t_cfg w_cfg;
    t_cmd w_push_cmd;
    t_cmd w_head;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;

    irpse_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    irpse_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_valid      (i_s_axis_tvalid),
        .i_data_byte  (i_s_axis_tdata),
        .i_final_byte (i_s_axis_tlast),
        .o_ready      (o_s_axis_tready),
        .i_q_full     (w_full),
        .o_push       (w_push),
        .o_cmd        (w_push_cmd)
    );

    irpse_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_push_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    irpse_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_head       (w_head),
        .i_q_empty    (w_empty),
        .o_pop        (w_pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_data       (o_m_axis_tdata),
        .o_item_done  (o_m_axis_tuser),
        .o_frame_done (o_m_axis_tlast)
    );

endmodule

/* sv/irpse_cfg.sv */
`timescale 1ns / 1ps
// Configuration register file with indexed write port.
module irpse_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [irpse_pkg::REG_IDX_W-1:0] i_cfg_index,
    input  logic [irpse_pkg::SYM_W-1:0]     i_cfg_data,
    output irpse_pkg::t_cfg                o_cfg
);
    import irpse_pkg::*;

    localparam t_cfg CFG_RESET = '{
        header_mark:  '0,
        header_space: '0,
        sym_zero:     '0,
        sym_one:      '0,
        footer_mark:  '0,
        footer_space: '0,
        bit_limit:    '0,
        msb_lead:     1'b1
    };

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_HEADER_MARK:  r_cfg.header_mark  <= i_cfg_data[DUR_W-1:0];
                REG_HEADER_SPACE: r_cfg.header_space <= i_cfg_data[DUR_W-1:0];
                REG_SYM_ZERO:     r_cfg.sym_zero     <= i_cfg_data;
                REG_SYM_ONE:      r_cfg.sym_one      <= i_cfg_data;
                REG_FOOTER_MARK:  r_cfg.footer_mark  <= i_cfg_data[DUR_W-1:0];
                REG_FOOTER_SPACE: r_cfg.footer_space <= i_cfg_data[DUR_W-1:0];
                REG_BIT_LIMIT:    r_cfg.bit_limit    <= i_cfg_data[LIMIT_W-1:0];
                REG_MSB_LEAD:     r_cfg.msb_lead     <= i_cfg_data[0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* sv/irpse_front.sv */
`timescale 1ns / 1ps
// Front end: accepts bytes, tracks frame state and bit count, builds commands.
module irpse_front #(
    parameter int COUNT_BITS = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  irpse_pkg::t_cfg             i_cfg,
    input  logic                        i_valid,
    input  logic [irpse_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                        i_final_byte,
    output logic                        o_ready,
    input  logic                        i_q_full,
    output logic                        o_push,
    output irpse_pkg::t_cmd             o_cmd
);
    import irpse_pkg::*;

    localparam int LW = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

    logic                  r_in_frame;
    logic [COUNT_BITS-1:0] r_bits_sent;
    logic [COUNT_BITS-1:0] n_bits_sent;

    logic [COUNT_BITS-1:0] w_base;
    logic [LW-1:0]         w_base_x;
    logic [LW-1:0]         w_lim_x;
    logic [LW-1:0]         w_cmax_x;
    logic [LW-1:0]         w_diff;
    logic                  w_free;
    logic [NBITS_W-1:0]    w_nbits;
    logic [COUNT_BITS:0]   w_sum;
    logic                  w_accept;
    t_foot                 w_foot;
    logic                  w_hdr;

    always_comb begin
        w_base   = r_in_frame ? r_bits_sent : '0;
        w_base_x = LW'(w_base);
        w_lim_x  = LW'(i_cfg.bit_limit);
        w_cmax_x = LW'({COUNT_BITS{1'b1}});
        w_diff   = w_lim_x - w_base_x;
        w_free   = (i_cfg.bit_limit == '0) || (w_lim_x > w_cmax_x);
        if (w_free) begin
            w_nbits = BITS_PER_BYTE;
        end else if (w_base_x >= w_lim_x) begin
            w_nbits = '0;
        end else if (w_diff >= LW'(BITS_PER_BYTE)) begin
            w_nbits = BITS_PER_BYTE;
        end else begin
            w_nbits = w_diff[NBITS_W-1:0];
        end
        w_sum = {1'b0, w_base} + (COUNT_BITS+1)'(w_nbits);
        n_bits_sent = w_sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : w_sum[COUNT_BITS-1:0];

        w_hdr = !r_in_frame && (i_cfg.header_mark != '0);
        if (!i_final_byte) begin
            w_foot = FOOT_NONE;
        end else if (i_cfg.footer_mark != '0) begin
            w_foot = FOOT_MARK;
        end else if (i_cfg.footer_space != '0) begin
            w_foot = FOOT_SPACE;
        end else begin
            w_foot = FOOT_NONE;
        end
    end

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;
    assign o_push   = w_accept && (w_hdr || (w_nbits != '0) || (w_foot != FOOT_NONE));

    assign o_cmd.data_byte = i_data_byte;
    assign o_cmd.hdr       = w_hdr;
    assign o_cmd.nbits     = w_nbits;
    assign o_cmd.foot      = w_foot;
    assign o_cmd.last      = i_final_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame  <= 1'b0;
            r_bits_sent <= '0;
        end else if (w_accept) begin
            r_in_frame  <= !i_final_byte;
            r_bits_sent <= n_bits_sent;
        end
    end

endmodule

/* sv/irpse_fifo.sv */
`timescale 1ns / 1ps
// Short command queue between front end and symbol sequencer.
module irpse_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  irpse_pkg::t_cmd i_wdata,
    input  logic            i_pop,
    output irpse_pkg::t_cmd o_head,
    output logic            o_full,
    output logic            o_empty
);
    import irpse_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

/* sv/irpse_back.sv */
`timescale 1ns / 1ps
// Symbol sequencer: walks header, data bits and footer, one symbol per cycle while the output is not stalled.
module irpse_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  irpse_pkg::t_cfg             i_cfg,
    input  irpse_pkg::t_cmd             i_head,
    input  logic                        i_q_empty,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [irpse_pkg::SYM_W-1:0] o_data,
    output logic                        o_item_done,
    output logic                        o_frame_done
);
    import irpse_pkg::*;

    typedef enum logic [1:0] {
        PH_HDR,
        PH_BIT,
        PH_FOOT
    } t_phase;

    t_phase       r_phase;
    logic [2:0]   r_idx;
    logic         r_busy;
    t_cmd         r_cmd;
    logic         r_out_valid;
    t_sym         r_sym;
    logic         r_item_done;
    logic         r_frame_done;

    t_phase             w_phase;
    t_phase             n_phase;
    logic [2:0]         w_idx;
    logic [2:0]         n_idx;
    logic [2:0]         w_pos;
    logic [NBITS_W-1:0] w_idx_inc;
    t_cmd               w_cmd;
    t_sym               w_sym;
    logic [SYM_W-1:0]   w_packed;
    logic               w_last;
    logic               w_act;
    logic               w_fire;

    always_comb begin
        w_cmd = r_busy ? r_cmd : i_head;
        w_idx = r_busy ? r_idx : '0;
        if (r_busy) begin
            w_phase = r_phase;
        end else if (i_head.hdr) begin
            w_phase = PH_HDR;
        end else if (i_head.nbits != '0) begin
            w_phase = PH_BIT;
        end else begin
            w_phase = PH_FOOT;
        end

        w_pos     = i_cfg.msb_lead ? 3'(BIT_IDX_MAX) - w_idx : w_idx;
        w_packed  = w_cmd.data_byte[w_pos] ? i_cfg.sym_one : i_cfg.sym_zero;
        w_idx_inc = {1'b0, w_idx} + NBITS_W'(1);

        w_sym   = '0;
        w_last  = 1'b1;
        n_phase = w_phase;
        n_idx   = w_idx;
        unique case (w_phase)
            PH_HDR: begin
                w_sym.first_duration  = i_cfg.header_mark;
                w_sym.first_level     = 1'b1;
                w_sym.second_duration = i_cfg.header_space;
                w_sym.second_level    = 1'b0;
                w_last  = (w_cmd.nbits == '0) && (w_cmd.foot == FOOT_NONE);
                n_phase = (w_cmd.nbits != '0) ? PH_BIT : PH_FOOT;
                n_idx   = '0;
            end
            PH_BIT: begin
                w_sym   = w_packed;
                w_last  = (w_idx_inc == w_cmd.nbits) && (w_cmd.foot == FOOT_NONE);
                n_phase = (w_idx_inc == w_cmd.nbits) ? PH_FOOT : PH_BIT;
                n_idx   = w_idx_inc[2:0];
            end
            PH_FOOT: begin
                if (w_cmd.foot == FOOT_MARK) begin
                    w_sym.first_duration  = i_cfg.footer_mark;
                    w_sym.first_level     = 1'b1;
                    w_sym.second_duration = i_cfg.footer_space;
                end else begin
                    w_sym.first_duration  = i_cfg.footer_space;
                end
                w_last = 1'b1;
            end
            default: begin
                w_last = 1'b1;
            end
        endcase

        w_act  = r_busy || !i_q_empty;
        w_fire = w_act && (!r_out_valid || i_ready);
    end

    assign o_pop = w_fire && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_HDR;
            r_idx       <= '0;
        end else if (w_fire) begin
            r_busy       <= !w_last;
            r_cmd        <= w_cmd;
            r_phase      <= n_phase;
            r_idx        <= n_idx;
            r_out_valid  <= 1'b1;
            r_sym        <= w_sym;
            r_item_done  <= w_last;
            r_frame_done <= w_last && w_cmd.last;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_data       = r_sym;
    assign o_item_done  = r_item_done;
    assign o_frame_done = r_frame_done;

`ifndef SYNTHESIS
    a_frame_implies_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_frame_done |-> r_item_done)
        else $error("frame end without byte end");
    a_bit_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && (r_phase == PH_BIT) |-> ({1'b0, r_idx} < r_cmd.nbits))
        else $error("bit index beyond command bit count");
    a_footer_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && (r_phase == PH_FOOT) |-> (r_cmd.foot != FOOT_NONE))
        else $error("footer phase without footer");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_q_empty)
        else $error("pop from empty queue");
`endif

endmodule
